@@ hdl/sbmd_pkg.sv @@
// Shared constants and codes for the spectrum bin magnitude / decibel core.
// Used by the log cells and the top level.
package sbmd_pkg;

  // Configuration register index
  typedef enum logic [0:0] {
    CFG_DB_FLOOR   = 1'b0,
    CFG_SILENCE_TH = 1'b1
  } cfg_idx_t;

  localparam int FLOOR_W  = 16;
  localparam int THRESH_W = 24;
  localparam int CFG_W    = 24;

  localparam logic signed [FLOOR_W-1:0] FLOOR_RST  = -16'sd23040;
  localparam logic [THRESH_W-1:0]       THRESH_RST = 24'd8;

  // Log2 mantissa in Q1.30, fraction of log2 in 16 bits
  localparam int NORM_W    = 31;
  localparam int LOG_FRAC_W = 16;
  localparam int LOG_STEPS = 16;

  // log2 value in Q.16 (signed), dB product, dB level before the floor clamp
  localparam int LOG_W   = 23;
  localparam int K_W     = 28;
  localparam int PROD_W  = LOG_W + K_W;
  localparam int LEVEL_W = PROD_W - 32;

  // 20*log10(2) in Q.24
  localparam logic signed [K_W-1:0] DB_K = 28'sd101008905;

endpackage

@@ hdl/spectrum_bin_magnitude_decibel_core.sv @@
// Registered path: squares, power, square-root cells, normalize, log2 cells, dB product, output.
// Throughput: one bin per cycle while the output is not stalled; the square-root chain has one cell per root bit
// and the log2 chain one cell per fraction bit, each a single register stage.
// All stages advance together; a stalled output holds the whole chain.
// Reset (rst_n, synchronous): clears all valid bits, loads the floor to -90 dB
// and the silence threshold to 8.
module spectrum_bin_magnitude_decibel_core #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_addr,
  input  logic [sbmd_pkg::CFG_W-1:0] cfg_wdata,
  // input bins
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tdata: real_part, imag_part (zero padded to bytes)
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input  logic                    in_tlast,   // bin_last
  // results
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // tdata: magnitude, power, level_db (zero padded to bytes)
  output logic [((3*SAMPLE_BITS+16+7)/8)*8-1:0] out_tdata,
  output logic                    out_tlast   // frame_last
);
  localparam int S   = SAMPLE_BITS;
  localparam int PW  = 2 * S;
  localparam int EW  = $clog2(S);
  localparam int FB  = S - 1;
  localparam int ODW = ((3 * S + 16 + 7) / 8) * 8;
  localparam int NW  = sbmd_pkg::NORM_W;
  localparam int FW  = sbmd_pkg::LOG_FRAC_W;
  localparam int LW  = sbmd_pkg::LOG_W;
  localparam int XW  = sbmd_pkg::PROD_W;
  localparam int VW  = sbmd_pkg::LEVEL_W;
  localparam int NSTEP = sbmd_pkg::LOG_STEPS;

  // Whole pipeline moves when the output register is free or being drained
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------- configuration registers ----------------
  logic signed [sbmd_pkg::FLOOR_W-1:0] db_floor_r;
  logic [sbmd_pkg::THRESH_W-1:0]       thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_floor_r <= sbmd_pkg::FLOOR_RST;
      thresh_r   <= sbmd_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbmd_pkg::CFG_DB_FLOOR:   db_floor_r <= cfg_wdata[sbmd_pkg::FLOOR_W-1:0];
        sbmd_pkg::CFG_SILENCE_TH: thresh_r   <= cfg_wdata[sbmd_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: squares ----------------
  logic signed [S-1:0] re_in, im_in;
  logic [S-1:0]        re_abs, im_abs;
  logic                s1_valid_r, s1_last_r;
  logic [PW-1:0]       sq_re_r, sq_im_r;

  assign re_in  = in_tdata[S-1:0];
  assign im_in  = in_tdata[2*S-1:S];
  assign re_abs = re_in[S-1] ? S'(-re_in) : S'(re_in);
  assign im_abs = im_in[S-1] ? S'(-im_in) : S'(im_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_re_r   <= PW'(re_abs) * PW'(re_abs);
      sq_im_r   <= PW'(im_abs) * PW'(im_abs);
      s1_last_r <= in_tlast;
    end
  end

  // ---------------- stage 2: exact power ----------------
  logic          s2_valid_r, s2_last_r;
  logic [PW-1:0] power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      power_r   <= sq_re_r + sq_im_r;
      s2_last_r <= s1_last_r;
    end
  end

  // ---------------- square-root chain, most significant root bit first ----------------
  logic          rt_valid [0:S];
  logic [PW-1:0] rt_rem   [0:S];
  logic [S-1:0]  rt_root  [0:S];
  logic [PW-1:0] rt_power [0:S];
  logic          rt_last  [0:S];

  assign rt_valid[0] = s2_valid_r;
  assign rt_rem[0]   = power_r;
  assign rt_root[0]  = '0;
  assign rt_power[0] = power_r;
  assign rt_last[0]  = s2_last_r;

  for (genvar k = 0; k < S; k++) begin : g_sqrt
    sbmd_sqrt_cell #(.SW(S), .BIT(S - 1 - k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (rt_valid[k]),
      .in_rem    (rt_rem[k]),
      .in_root   (rt_root[k]),
      .in_power  (rt_power[k]),
      .in_last   (rt_last[k]),
      .out_valid (rt_valid[k+1]),
      .out_rem   (rt_rem[k+1]),
      .out_root  (rt_root[k+1]),
      .out_power (rt_power[k+1]),
      .out_last  (rt_last[k+1])
    );
  end

  // ---------------- normalize magnitude to Q1.30 ----------------
  logic [S-1:0]  mag;
  logic [EW-1:0] msb_idx;
  logic [63:0]   mag_ext, norm_full;

  assign mag = rt_root[S];

  always_comb begin
    msb_idx = '0;
    for (int b = 0; b < S; b++) begin
      if (mag[b]) msb_idx = EW'(b);
    end
    mag_ext = 64'(mag);
    if (int'(msb_idx) <= NW - 1) begin
      norm_full = mag_ext << (NW - 1 - int'(msb_idx));
    end else begin
      norm_full = mag_ext >> (int'(msb_idx) - (NW - 1));
    end
  end

  logic          nm_valid_r, nm_last_r;
  logic [NW-1:0] nm_y_r;
  logic [EW-1:0] nm_exp_r;
  logic [S-1:0]  nm_mag_r;
  logic [PW-1:0] nm_power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_valid_r <= 1'b0;
    end else if (adv) begin
      nm_valid_r <= rt_valid[S];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_y_r     <= norm_full[NW-1:0];
      nm_exp_r   <= msb_idx;
      nm_mag_r   <= mag;
      nm_power_r <= rt_power[S];
      nm_last_r  <= rt_last[S];
    end
  end

  // ---------------- log2 fraction chain ----------------
  logic          lg_valid [0:NSTEP];
  logic [NW-1:0] lg_y     [0:NSTEP];
  logic [FW-1:0] lg_frac  [0:NSTEP];
  logic [EW-1:0] lg_exp   [0:NSTEP];
  logic [S-1:0]  lg_mag   [0:NSTEP];
  logic [PW-1:0] lg_power [0:NSTEP];
  logic          lg_last  [0:NSTEP];

  assign lg_valid[0] = nm_valid_r;
  assign lg_y[0]     = nm_y_r;
  assign lg_frac[0]  = '0;
  assign lg_exp[0]   = nm_exp_r;
  assign lg_mag[0]   = nm_mag_r;
  assign lg_power[0] = nm_power_r;
  assign lg_last[0]  = nm_last_r;

  for (genvar k = 0; k < NSTEP; k++) begin : g_log
    sbmd_log_cell #(.SW(S), .EW(EW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (lg_valid[k]),
      .in_y      (lg_y[k]),
      .in_frac   (lg_frac[k]),
      .in_exp    (lg_exp[k]),
      .in_mag    (lg_mag[k]),
      .in_power  (lg_power[k]),
      .in_last   (lg_last[k]),
      .out_valid (lg_valid[k+1]),
      .out_y     (lg_y[k+1]),
      .out_frac  (lg_frac[k+1]),
      .out_exp   (lg_exp[k+1]),
      .out_mag   (lg_mag[k+1]),
      .out_power (lg_power[k+1]),
      .out_last  (lg_last[k+1])
    );
  end

  // ---------------- scale log2 to dB (Q.16 times Q.24) ----------------
  logic signed [LW-1:0] log_q16;

  // Remove the Q1.(S-1) scaling of the magnitude: subtract FB in Q.16
  assign log_q16 = $signed({{(LW - FW - EW){1'b0}}, lg_exp[NSTEP], lg_frac[NSTEP]})
                   - $signed(LW'(FB) << FW);

  logic                 mu_valid_r, mu_last_r;
  logic signed [XW-1:0] mu_prod_r;
  logic [S-1:0]         mu_mag_r;
  logic [PW-1:0]        mu_power_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_valid_r <= 1'b0;
    end else if (adv) begin
      mu_valid_r <= lg_valid[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mu_prod_r  <= XW'(log_q16) * XW'(sbmd_pkg::DB_K);
      mu_mag_r   <= lg_mag[NSTEP];
      mu_power_r <= lg_power[NSTEP];
      mu_last_r  <= lg_last[NSTEP];
    end
  end

  // ---------------- round, clamp at the floor (also when silent), hold for the consumer ----------------
  logic signed [XW-1:0]  prod_rnd;
  logic signed [VW-1:0]  level_raw;
  logic signed [VW-1:0]  floor_ext;
  logic                  silent;
  logic [15:0]           level_out;

  always_comb begin
    prod_rnd  = mu_prod_r + (XW'(1) <<< 31);
    level_raw = prod_rnd[XW-1:32];   // floor division by 2^32
    floor_ext = VW'(db_floor_r);
    silent    = 33'(mu_mag_r) <= 33'(thresh_r);
    if (silent || (level_raw < floor_ext)) begin
      level_out = db_floor_r;
    end else begin
      level_out = level_raw[15:0];
    end
  end

  logic            out_valid_r, out_last_r;
  logic [ODW-1:0]  out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= mu_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= ODW'({level_out, mu_power_r, mu_mag_r});
      out_last_r <= mu_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule

@@ hdl/sbmd_sqrt_cell.sv @@
// One restoring square-root cell: decides one root bit per request.
// Depends on nothing beyond its parameters.
module sbmd_sqrt_cell #(
  parameter int SW  = 24,
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*SW-1:0] in_rem,
  input  logic [SW-1:0]   in_root,
  input  logic [2*SW-1:0] in_power,
  input  logic            in_last,
  output logic            out_valid,
  output logic [2*SW-1:0] out_rem,
  output logic [SW-1:0]   out_root,
  output logic [2*SW-1:0] out_power,
  output logic            out_last
);
  localparam int TW = 2 * SW + 1;

  logic [TW-1:0]   trial;
  logic [TW-1:0]   rem_ext;
  logic            take;
  logic [2*SW-1:0] rem_nxt;
  logic [SW-1:0]   root_nxt;
  logic            valid_r;
  logic [2*SW-1:0] rem_r;
  logic [SW-1:0]   root_r;
  logic [2*SW-1:0] power_r;
  logic            last_r;

  // (R + 2^i)^2 - R^2 = R*2^(i+1) + 2^(2i)
  always_comb begin
    rem_ext  = TW'(in_rem);
    trial    = (TW'(in_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    take     = rem_ext >= trial;
    rem_nxt  = take ? (2*SW)'(rem_ext - trial) : in_rem;
    root_nxt = take ? (in_root | (SW'(1) << BIT)) : in_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r   <= rem_nxt;
      root_r  <= root_nxt;
      power_r <= in_power;
      last_r  <= in_last;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_power = power_r;
  assign out_last  = last_r;
endmodule

@@ hdl/sbmd_log_cell.sv @@
// One log2 fraction cell: squares the normalized mantissa and yields one bit.
// Depends on sbmd_pkg for the mantissa and fraction widths.
module sbmd_log_cell #(
  parameter int SW = 24,
  parameter int EW = 5
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [sbmd_pkg::NORM_W-1:0]      in_y,
  input  logic [sbmd_pkg::LOG_FRAC_W-1:0]  in_frac,
  input  logic [EW-1:0]                    in_exp,
  input  logic [SW-1:0]                    in_mag,
  input  logic [2*SW-1:0]                  in_power,
  input  logic                             in_last,
  output logic                             out_valid,
  output logic [sbmd_pkg::NORM_W-1:0]      out_y,
  output logic [sbmd_pkg::LOG_FRAC_W-1:0]  out_frac,
  output logic [EW-1:0]                    out_exp,
  output logic [SW-1:0]                    out_mag,
  output logic [2*SW-1:0]                  out_power,
  output logic                             out_last
);
  localparam int NW = sbmd_pkg::NORM_W;
  localparam int FW = sbmd_pkg::LOG_FRAC_W;

  logic [2*NW-1:0] sq;
  logic [NW:0]     y2;
  logic            bit_set;
  logic [NW-1:0]   y_nxt;
  logic [FW-1:0]   frac_nxt;
  logic            valid_r;
  logic [NW-1:0]   y_r;
  logic [FW-1:0]   frac_r;
  logic [EW-1:0]   exp_r;
  logic [SW-1:0]   mag_r;
  logic [2*SW-1:0] power_r;
  logic            last_r;

  // Square in Q1.30, truncate; a value of 2 or more renormalizes and sets the bit
  always_comb begin
    sq       = (2*NW)'(in_y) * (2*NW)'(in_y);
    y2       = sq[2*NW-1:NW-1];
    bit_set  = y2[NW];
    y_nxt    = bit_set ? y2[NW:1] : y2[NW-1:0];
    frac_nxt = {in_frac[FW-2:0], bit_set};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r     <= y_nxt;
      frac_r  <= frac_nxt;
      exp_r   <= in_exp;
      mag_r   <= in_mag;
      power_r <= in_power;
      last_r  <= in_last;
    end
  end

  assign out_valid = valid_r;
  assign out_y     = y_r;
  assign out_frac  = frac_r;
  assign out_exp   = exp_r;
  assign out_mag   = mag_r;
  assign out_power = power_r;
  assign out_last  = last_r;
endmodule
